/* hw/rtl/adll_pkg.sv */
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types, constants and helpers for the array based doubly linked list.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int FIELD_W   = 10;
  localparam int NODES_DEF = 1024;

  typedef enum logic [1:0] {
    OP_INS_LEFT  = 2'd0,
    OP_INS_RIGHT = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_QUERY     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_WR1,
    S_WR2
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic rd_port;
    logic reduce_step;
    logic wr1;
    logic wr2;
    logic load_out;
    logic clr_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  // node numbers need a remainder step only for a store depth that is
  // below the field range and not a power of two
  function automatic bit need_mod(input int n);
    return (n < (1 << FIELD_W)) && ((n & (n - 1)) != 0);
  endfunction

endpackage

/* hw/rtl/array_doubly_linked_list.sv */
// result: registered at the end of the second write step, once the output is free;
//   when NODES is below 1024 and not a power of two, the two node number remainder
//   steps and a link read come first; a new item is taken only after the read and
//   the two write steps on the link stores of the last one (and its remainder steps)
// reset: a clearing sweep over all NODES entries zeroes both link stores, no input
//   transfer is taken meanwhile; the head starts at node 1
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list of numbered nodes kept in left and right link stores.
// ----------------------------------------------------------------------------
module array_doubly_linked_list #(
  parameter int NODES = adll_pkg::NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [adll_pkg::FIELD_W-1:0]  node,
  input  logic [adll_pkg::FIELD_W-1:0]  anchor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [adll_pkg::FIELD_W-1:0]  head_node,
  output logic [adll_pkg::FIELD_W-1:0]  left_neighbor,
  output logic [adll_pkg::FIELD_W-1:0]  right_neighbor
);

  adll_pkg::cmd_t cmd;
  adll_pkg::sts_t sts;

  adll_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  adll_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .op             (op),
    .node           (node),
    .anchor         (anchor),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .head_node      (head_node),
    .left_neighbor  (left_neighbor),
    .right_neighbor (right_neighbor)
  );

endmodule

/* hw/rtl/adll_ctrl.sv */
// ----------------------------------------------------------------------------
// adll_ctrl
// Sequencer for the linked list: clearing sweep, node number reduction,
// link read and the two link write steps.
// ----------------------------------------------------------------------------
module adll_ctrl #(
  parameter int NODES = adll_pkg::NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output adll_pkg::cmd_t   cmd,
  input  adll_pkg::sts_t   sts
);

  localparam bit NEED_MOD = adll_pkg::need_mod(NODES);
  localparam int RSTEPS   = 2;
  localparam int RW       = $clog2(RSTEPS);

  adll_pkg::state_t state;
  adll_pkg::state_t state_next;
  logic [RW-1:0]    rcnt;
  logic             rlast;

  assign rlast = (rcnt == RW'(RSTEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adll_pkg::S_CLEAR;
      rcnt  <= '0;
    end else begin
      state <= state_next;
      if (state == adll_pkg::S_REDUCE) begin
        rcnt <= rcnt + RW'(1);
      end else begin
        rcnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      adll_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = adll_pkg::S_IDLE;
        end
      end
      adll_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.rd_en   = 1'b1;
        cmd.rd_port = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = NEED_MOD ? adll_pkg::S_REDUCE : adll_pkg::S_WR1;
        end
      end
      adll_pkg::S_REDUCE: begin
        cmd.reduce_step = 1'b1;
        if (rlast) begin
          state_next = adll_pkg::S_READ;
        end
      end
      adll_pkg::S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = adll_pkg::S_WR1;
      end
      adll_pkg::S_WR1: begin
        cmd.wr1    = 1'b1;
        state_next = adll_pkg::S_WR2;
      end
      adll_pkg::S_WR2: begin
        // second write step repeats harmlessly while the result waits
        cmd.wr2 = 1'b1;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = adll_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = adll_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/adll_dpath.sv */
// ----------------------------------------------------------------------------
// adll_dpath
// Link stores, head register, item registers, node number reduction and the
// result register of the linked list.
// ----------------------------------------------------------------------------
module adll_dpath #(
  parameter int NODES = adll_pkg::NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  adll_pkg::cmd_t                cmd,
  output adll_pkg::sts_t                sts,
  input  logic [1:0]                    op,
  input  logic [adll_pkg::FIELD_W-1:0]  node,
  input  logic [adll_pkg::FIELD_W-1:0]  anchor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [adll_pkg::FIELD_W-1:0]  head_node,
  output logic [adll_pkg::FIELD_W-1:0]  left_neighbor,
  output logic [adll_pkg::FIELD_W-1:0]  right_neighbor
);

  localparam int  FW       = adll_pkg::FIELD_W;
  localparam int  IW       = $clog2(NODES);
  localparam bit  NEED_MOD = adll_pkg::need_mod(NODES);

  logic [IW-1:0] left_mem  [NODES];
  logic [IW-1:0] right_mem [NODES];

  adll_pkg::op_t opr;
  logic [IW-1:0] ni;
  logic [IW-1:0] ai;
  logic [IW-1:0] ni_load;
  logic [IW-1:0] ai_load;
  logic [IW-1:0] ni_red;
  logic [IW-1:0] ai_red;
  logic [IW-1:0] node_conv;
  logic [IW-1:0] anchor_conv;
  logic [IW-1:0] head;
  logic [IW-1:0] clr_addr;
  logic [IW-1:0] rl;
  logic [IW-1:0] rr;
  logic [IW-1:0] rd_addr;

  logic          wl_en;
  logic          wr_en;
  logic [IW-1:0] wl_addr;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wl_data;
  logic [IW-1:0] wr_data;
  logic          wl_go;
  logic          wr_go;

  logic [IW-1:0] res_l;
  logic [IW-1:0] res_r;
  logic [FW-1:0] head_f;
  logic [FW-1:0] res_l_f;
  logic [FW-1:0] res_r_f;

  // port field to store index
  if (IW > FW) begin : g_ext
    assign node_conv   = {{(IW - FW){1'b0}}, node};
    assign anchor_conv = {{(IW - FW){1'b0}}, anchor};
    assign head_f      = head[FW-1:0];
    assign res_l_f     = res_l[FW-1:0];
    assign res_r_f     = res_r[FW-1:0];
  end else if (IW == FW) begin : g_same
    assign node_conv   = node;
    assign anchor_conv = anchor;
    assign head_f      = head;
    assign res_l_f     = res_l;
    assign res_r_f     = res_r;
  end else begin : g_trunc
    assign node_conv   = node[IW-1:0];
    assign anchor_conv = anchor[IW-1:0];
    assign head_f      = {{(FW - IW){1'b0}}, head};
    assign res_l_f     = {{(FW - IW){1'b0}}, res_l};
    assign res_r_f     = {{(FW - IW){1'b0}}, res_r};
  end

  // remainder by reciprocal multiply, then one correcting subtract
  if (NEED_MOD) begin : g_mod
    localparam int            QS    = 2 * FW;
    localparam logic [QS-1:0] RECIP = QS'((1 << QS) / NODES);

    logic [FW-1:0]    raw_n;
    logic [FW-1:0]    raw_a;
    logic [FW-1:0]    qn;
    logic [FW-1:0]    qa;
    logic [FW+QS-1:0] pn;
    logic [FW+QS-1:0] pa;
    logic [2*FW-1:0]  mn;
    logic [2*FW-1:0]  ma;
    logic [FW-1:0]    tn;
    logic [FW-1:0]    ta;

    always_ff @(posedge clk) begin
      if (cmd.load_in) begin
        raw_n <= node;
        raw_a <= anchor;
      end
      qn <= pn[FW+QS-1:QS];
      qa <= pa[FW+QS-1:QS];
    end

    assign pn      = {{QS{1'b0}}, raw_n} * {{FW{1'b0}}, RECIP};
    assign pa      = {{QS{1'b0}}, raw_a} * {{FW{1'b0}}, RECIP};
    assign mn      = {{FW{1'b0}}, qn} * (2*FW)'(NODES);
    assign ma      = {{FW{1'b0}}, qa} * (2*FW)'(NODES);
    assign tn      = raw_n - mn[FW-1:0];
    assign ta      = raw_a - ma[FW-1:0];
    assign ni_red  = (tn >= FW'(NODES)) ? IW'(tn - FW'(NODES)) : IW'(tn);
    assign ai_red  = (ta >= FW'(NODES)) ? IW'(ta - FW'(NODES)) : IW'(ta);
    assign ni_load = '0;
    assign ai_load = '0;
  end else begin : g_nomod
    assign ni_red  = ni;
    assign ai_red  = ai;
    assign ni_load = node_conv;
    assign ai_load = anchor_conv;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      opr <= adll_pkg::op_t'(op);
      ni  <= ni_load;
      ai  <= ai_load;
    end else if (cmd.reduce_step) begin
      ni <= ni_red;
      ai <= ai_red;
    end
  end

  // read address: anchor for inserts, node otherwise
  always_comb begin
    if (cmd.rd_port) begin
      rd_addr = (op[1] == 1'b0) ? anchor_conv : node_conv;
    end else begin
      rd_addr = (opr == adll_pkg::OP_INS_LEFT || opr == adll_pkg::OP_INS_RIGHT) ? ai : ni;
    end
  end

  // link writes; the sentinel entry is never written outside the sweep
  always_comb begin
    wl_en   = 1'b0;
    wr_en   = 1'b0;
    wl_addr = '0;
    wr_addr = '0;
    wl_data = '0;
    wr_data = '0;
    priority if (cmd.clr_en) begin
      wl_en   = 1'b1;
      wr_en   = 1'b1;
      wl_addr = clr_addr;
      wr_addr = clr_addr;
    end else if (cmd.wr1) begin
      unique case (opr)
        adll_pkg::OP_INS_LEFT: begin
          wr_en = 1'b1; wr_addr = ni; wr_data = ai;
          wl_en = 1'b1; wl_addr = ni; wl_data = rl;
        end
        adll_pkg::OP_INS_RIGHT: begin
          wl_en = 1'b1; wl_addr = ni; wl_data = ai;
          wr_en = 1'b1; wr_addr = ni; wr_data = rr;
        end
        adll_pkg::OP_REMOVE: begin
          wl_en = 1'b1; wl_addr = ni;
          wr_en = 1'b1; wr_addr = ni;
        end
        adll_pkg::OP_QUERY: begin
        end
      endcase
    end else if (cmd.wr2) begin
      unique case (opr)
        adll_pkg::OP_INS_LEFT: begin
          wr_en = 1'b1; wr_addr = rl; wr_data = ni;
          wl_en = 1'b1; wl_addr = ai; wl_data = ni;
        end
        adll_pkg::OP_INS_RIGHT: begin
          wl_en = 1'b1; wl_addr = rr; wl_data = ni;
          wr_en = 1'b1; wr_addr = ai; wr_data = ni;
        end
        adll_pkg::OP_REMOVE: begin
          wr_en = 1'b1; wr_addr = rl; wr_data = rr;
          wl_en = 1'b1; wl_addr = rr; wl_data = rl;
        end
        adll_pkg::OP_QUERY: begin
        end
      endcase
    end else begin
    end
  end

  assign wl_go = wl_en && (cmd.clr_en || wl_addr != '0);
  assign wr_go = wr_en && (cmd.clr_en || wr_addr != '0);

  always_ff @(posedge clk) begin
    if (wl_go) begin
      left_mem[wl_addr] <= wl_data;
    end
    if (cmd.rd_en) begin
      rl <= left_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      right_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rr <= right_mem[rd_addr];
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + IW'(1);
    end
  end

  assign sts.clr_last = (clr_addr == IW'(NODES - 1));
  assign sts.out_free = !out_valid || !out_stall;

  // head update
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= IW'(1);
    end else if (cmd.wr1) begin
      if (opr == adll_pkg::OP_INS_LEFT && ai == head) begin
        head <= ni;
      end else if (opr == adll_pkg::OP_REMOVE && ni == head) begin
        head <= rr;
      end
    end
  end

  // node links after both write steps
  always_comb begin
    res_l = '0;
    res_r = '0;
    unique case (opr)
      adll_pkg::OP_INS_LEFT: begin
        res_l = (ai == ni) ? ni : rl;
        res_r = (rl == ni) ? ni : ai;
      end
      adll_pkg::OP_INS_RIGHT: begin
        res_l = (rr == ni) ? ni : ai;
        res_r = (ai == ni) ? ni : rr;
      end
      adll_pkg::OP_REMOVE: begin
        res_l = (rr == ni) ? rl : '0;
        res_r = (rl == ni) ? rr : '0;
      end
      adll_pkg::OP_QUERY: begin
        res_l = rl;
        res_r = rr;
      end
    endcase
    if (ni == '0) begin
      res_l = '0;
      res_r = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      head_node      <= head_f;
      left_neighbor  <= res_l_f;
      right_neighbor <= res_r_f;
    end
  end

endmodule
